FILE: src/sac_pkg.sv
// Shared types, sizes and helpers for the set-associative write-through cache.
`default_nettype none
package sac_pkg;

    // Geometry of memory and cache.
    localparam int MEM_BYTES  = 65536;
    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int LINE_BYTES = 128;
    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int SET_COUNT  = 4;
    localparam int SET_W      = $clog2(SET_COUNT);
    localparam int WAY_COUNT  = 8;
    localparam int WAY_W      = $clog2(WAY_COUNT);
    localparam int LINE_TOTAL = SET_COUNT * WAY_COUNT;
    localparam int LINE_IDX_W = SET_W + WAY_W;
    localparam int TAG_W      = ADDR_W - OFF_W - SET_W;
    localparam int DATA_RAM_DEPTH = LINE_TOTAL * LINE_BYTES;
    localparam int DATA_RAM_AW    = $clog2(DATA_RAM_DEPTH);
    localparam int FILL_CNT_W = OFF_W + 1;
    localparam int CNT_W      = 32;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Input transaction.
    typedef struct packed {
        cmd_t              command;
        logic [ADDR_W-1:0] address;
        logic [7:0]        write_data;
    } in_item_t;

    // Output transaction.
    typedef struct packed {
        logic [7:0]       read_data;
        logic             was_hit;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] access_total;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FILL,
        S_AGE,
        S_RDWAIT,
        S_DONE
    } state_t;

    // Controls from the sequencer to the tag directory.
    typedef struct packed {
        logic             scan_en;
        logic             update_en;
        logic             fill_en;
        logic             flush_en;
        logic [SET_W-1:0] set;
        logic [WAY_W-1:0] way;
        logic [WAY_W-1:0] fill_way;
        logic [TAG_W-1:0] tag;
    } dir_ctrl_t;

    // Status from the tag directory.
    typedef struct packed {
        logic             cur_match;
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic [WAY_W-1:0] victim;
    } dir_stat_t;

    // Saturating increment of a 32-bit count.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

FILE: src/sac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

FILE: src/sac_dir.sv
// Tag directory: valid bits, tags and ages, with a one-way-per-cycle compare unit.
`default_nettype none
module sac_dir
    import sac_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dir_ctrl_t ctrl,
    output dir_stat_t      stat
);

    logic             valid_reg [LINE_TOTAL];
    logic [TAG_W-1:0] tag_reg   [LINE_TOTAL];
    logic [CNT_W-1:0] age_reg   [LINE_TOTAL];

    logic             hit_reg;
    logic [WAY_W-1:0] hit_way_reg;
    logic [WAY_W-1:0] best_reg;
    logic [CNT_W-1:0] best_age_reg;
    logic             have_inv_reg;

    logic [LINE_IDX_W-1:0] cur_idx;
    logic [LINE_IDX_W-1:0] fill_idx;
    logic                  cur_valid;
    logic [CNT_W-1:0]      cur_age;
    logic                  cur_match;

    // Compare unit for the way under scan.
    always_comb
    begin
        cur_idx   = {ctrl.set, ctrl.way};
        fill_idx  = {ctrl.set, ctrl.fill_way};
        cur_valid = valid_reg[cur_idx];
        cur_age   = age_reg[cur_idx];
        cur_match = cur_valid && (tag_reg[cur_idx] == ctrl.tag);
    end

    assign stat.cur_match = cur_match;
    assign stat.hit       = hit_reg;
    assign stat.hit_way   = hit_way_reg;
    assign stat.victim    = best_reg;

    // Hit and victim accumulation over the scan; the first way restarts it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            have_inv_reg <= 1'b0;
        end
        else if (ctrl.scan_en)
        begin
            if (ctrl.way == '0)
            begin
                hit_reg      <= cur_match;
                have_inv_reg <= !cur_valid;
            end
            else
            begin
                if (cur_match)
                begin
                    hit_reg <= 1'b1;
                end
                if (!cur_valid)
                begin
                    have_inv_reg <= 1'b1;
                end
            end
        end
    end

    // Way numbers and age of the current best victim.
    always_ff @(posedge clk)
    begin
        if (ctrl.scan_en)
        begin
            if (cur_match)
            begin
                hit_way_reg <= ctrl.way;
            end
            if (ctrl.way == '0)
            begin
                best_reg     <= '0;
                best_age_reg <= cur_age;
            end
            else if (!cur_valid)
            begin
                best_reg <= ctrl.way;
            end
            else if (!have_inv_reg && (cur_age > best_age_reg))
            begin
                best_reg     <= ctrl.way;
                best_age_reg <= cur_age;
            end
        end
    end

    // Valid bits: cleared by flush, set by a fill.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LINE_TOTAL; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (ctrl.flush_en)
        begin
            for (int k = 0; k < LINE_TOTAL; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (ctrl.update_en && ctrl.fill_en)
        begin
            valid_reg[fill_idx] <= 1'b1;
        end
    end

    // Tags and ages: every read ages all lines, a filled line restarts at one.
    always_ff @(posedge clk)
    begin
        if (ctrl.update_en)
        begin
            for (int k = 0; k < LINE_TOTAL; k++)
            begin
                if (ctrl.fill_en && (LINE_IDX_W'(k) == fill_idx))
                begin
                    age_reg[k] <= CNT_W'(1);
                end
                else
                begin
                    age_reg[k] <= sat_inc(age_reg[k]);
                end
            end
            if (ctrl.fill_en)
            begin
                tag_reg[fill_idx] <= ctrl.tag;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/set_assoc_cache_fifo_wt.sv
// Top level of the set-associative write-through cache with its sequencer.
//
// A 4-set, 8-way cache of 128-byte lines in front of a 64 KiB byte memory.
// One transaction is handled at a time; in_ready is high only while the
// sequencer is idle. The tag directory is searched one way per cycle by a
// single compare unit, and a read miss adds a line fill, which copies one
// byte per cycle through the memory read port. After reset and after every
// flush the memory is cleared by a sweep, one byte per cycle; no transaction
// is accepted during the sweep, and a flush delivers its result when the
// sweep ends. The result register holds a finished result until it is taken.
`default_nettype none
module set_assoc_cache_fifo_wt
    import sac_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    state_t state_reg, state_next;

    cmd_t                  cmd_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [7:0]            wdata_reg;
    logic [WAY_W-1:0]      way_reg;
    logic [WAY_W-1:0]      sel_way_reg;
    logic                  miss_reg;
    logic [FILL_CNT_W-1:0] fill_cnt_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic                  flush_pend_reg;
    logic [7:0]            rdata_reg;
    logic [CNT_W-1:0]      miss_cnt_reg;
    logic [CNT_W-1:0]      access_cnt_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic accept;
    logic out_load;

    logic [OFF_W-1:0] offset;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;

    dir_ctrl_t dir_ctrl;
    dir_stat_t dir_stat;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    logic                   line_we;
    logic [DATA_RAM_AW-1:0] line_waddr;
    logic [7:0]             line_wdata;
    logic [DATA_RAM_AW-1:0] line_raddr;
    logic [7:0]             line_rdata;

    assign offset  = addr_reg[OFF_W-1:0];
    assign set_idx = addr_reg[OFF_W +: SET_W];
    assign tag     = addr_reg[ADDR_W-1 -: TAG_W];

    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (&clr_cnt_reg)
                begin
                    state_next = flush_pend_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_item.command)
                        CMD_READ, CMD_WRITE: state_next = S_SCAN;
                        CMD_FLUSH:           state_next = S_CLEAR;
                        CMD_NONE:            state_next = S_DONE;
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (&way_reg)
                begin
                    state_next = (cmd_reg == CMD_READ) ? S_DECIDE : S_DONE;
                end
            end
            S_DECIDE: state_next = dir_stat.hit ? S_AGE : S_FILL;
            S_FILL:
            begin
                if (fill_cnt_reg == FILL_CNT_W'(LINE_BYTES))
                begin
                    state_next = S_AGE;
                end
            end
            S_AGE:    state_next = S_RDWAIT;
            S_RDWAIT: state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Output logic of the sequencer: handshake, RAM ports and directory controls.
    always_comb
    begin
        in_ready = (state_reg == S_IDLE);

        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = 8'd0;
        mem_raddr = {addr_reg[ADDR_W-1:OFF_W], fill_cnt_reg[OFF_W-1:0]};

        line_we    = 1'b0;
        line_waddr = {set_idx, way_reg, offset};
        line_wdata = wdata_reg;
        line_raddr = {set_idx, sel_way_reg, offset};

        dir_ctrl           = '0;
        dir_ctrl.set       = set_idx;
        dir_ctrl.way       = way_reg;
        dir_ctrl.fill_way  = sel_way_reg;
        dir_ctrl.tag       = tag;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                // A write goes through to memory as it is accepted.
                if (accept && (in_item.command == CMD_WRITE))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = in_item.address;
                    mem_wdata = in_item.write_data;
                end
                dir_ctrl.flush_en = accept && (in_item.command == CMD_FLUSH);
            end
            S_SCAN:
            begin
                dir_ctrl.scan_en = 1'b1;
                line_we = (cmd_reg == CMD_WRITE) && dir_stat.cur_match;
            end
            S_FILL:
            begin
                line_we    = (fill_cnt_reg != '0);
                line_waddr = {set_idx, sel_way_reg,
                              OFF_W'(fill_cnt_reg - FILL_CNT_W'(1))};
                line_wdata = mem_rdata;
            end
            S_AGE:
            begin
                dir_ctrl.update_en = 1'b1;
                dir_ctrl.fill_en   = miss_reg;
            end
            S_DECIDE, S_RDWAIT, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            flush_pend_reg <= 1'b0;
            way_reg        <= '0;
            fill_cnt_reg   <= '0;
            miss_cnt_reg   <= '0;
            access_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Memory clearing sweep.
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end

            // Start of a transaction.
            if (accept)
            begin
                way_reg        <= '0;
                fill_cnt_reg   <= '0;
                flush_pend_reg <= (in_item.command == CMD_FLUSH);
                if (in_item.command == CMD_FLUSH)
                begin
                    miss_cnt_reg <= '0;
                end
            end

            if (state_reg == S_SCAN)
            begin
                way_reg <= way_reg + WAY_W'(1);
            end

            if (state_reg == S_FILL)
            begin
                fill_cnt_reg <= fill_cnt_reg + FILL_CNT_W'(1);
            end

            // Counters move once per read.
            if (state_reg == S_AGE)
            begin
                access_cnt_reg <= sat_inc(access_cnt_reg);
                if (miss_reg)
                begin
                    miss_cnt_reg <= sat_inc(miss_cnt_reg);
                end
            end

            // Result register.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction payload and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= in_item.command;
            addr_reg  <= in_item.address;
            wdata_reg <= in_item.write_data;
            rdata_reg <= 8'd0;
            miss_reg  <= 1'b0;
        end
        if (state_reg == S_DECIDE)
        begin
            miss_reg    <= !dir_stat.hit;
            sel_way_reg <= dir_stat.hit ? dir_stat.hit_way : dir_stat.victim;
        end
        if (state_reg == S_RDWAIT)
        begin
            rdata_reg <= line_rdata;
        end
        if (out_load)
        begin
            out_reg.read_data    <= rdata_reg;
            out_reg.was_hit      <= (cmd_reg == CMD_READ) && !miss_reg;
            out_reg.miss_total   <= miss_cnt_reg;
            out_reg.access_total <= access_cnt_reg;
        end
    end

    // Tag directory with its compare unit.
    sac_dir u_dir (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dir_ctrl),
        .stat  (dir_stat)
    );

    // Main memory.
    sac_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Cache line data.
    sac_ram #(
        .WIDTH (8),
        .DEPTH (DATA_RAM_DEPTH)
    ) u_lines (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Misses are a subset of reads since reset, so never exceed the access count.
    assert property (@(posedge clk) disable iff (!rst_n)
        miss_cnt_reg <= access_cnt_reg)
        else $error("miss count exceeds access count");

    // A line fill only follows a lookup that missed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> !dir_stat.hit)
        else $error("line fill after a hit");

    // A new result appears only when the sequencer finishes a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    // Nothing is accepted while the memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !$past(accept))
        else $error("transaction accepted during clearing sweep");

endmodule
`default_nettype wire

FILE: tb/sac_checker.sv
// Checker that predicts the cache results from accepted commands and compares them.
module sac_checker
    import sac_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire in_item_t  in_item,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire out_item_t out_item,
    output int             fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of memory and cache contents.
    logic [7:0]       mem_shadow [MEM_BYTES];
    logic [7:0]       line_data  [LINE_TOTAL][LINE_BYTES];
    logic             line_vld   [LINE_TOTAL];
    logic [TAG_W-1:0] line_tg    [LINE_TOTAL];
    logic [CNT_W-1:0] line_ag    [LINE_TOTAL];
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] reads;

    out_item_t expected_results[$];
    int        err_count;

    // Reports one mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1;
    endfunction

    // Applies one command to the shadow state and returns its result.
    function automatic out_item_t cache_result(input in_item_t it);
        out_item_t        r;
        logic [SET_W-1:0] set;
        logic [TAG_W-1:0] tag;
        logic [OFF_W-1:0] off;
        int               base;
        int               way;
        int               k;
        logic             have_invalid;
        set  = it.address[OFF_W +: SET_W];
        tag  = it.address[ADDR_W-1 -: TAG_W];
        off  = it.address[OFF_W-1:0];
        base = int'(set) * WAY_COUNT;
        r    = '0;
        case (it.command)
            CMD_READ:
            begin
                way = -1;
                for (int w = 0; w < WAY_COUNT; w++)
                    if (line_vld[base+w] && line_tg[base+w] == tag)
                        way = w;
                if (way < 0)
                begin
                    // Victim: highest invalid way, else lowest oldest way.
                    way = 0;
                    have_invalid = 1'b0;
                    for (int w = 0; w < WAY_COUNT; w++)
                    begin
                        if (!line_vld[base+w])
                        begin
                            way = w;
                            have_invalid = 1'b1;
                        end
                        else if (!have_invalid && line_ag[base+w] > line_ag[base+way])
                            way = w;
                    end
                    k = base + way;
                    for (int i = 0; i < LINE_BYTES; i++)
                        line_data[k][i] = mem_shadow[{it.address[ADDR_W-1:OFF_W], OFF_W'(i)}];
                    line_tg[k]  = tag;
                    line_ag[k]  = '0;
                    line_vld[k] = 1'b1;
                    misses = bump(misses);
                end
                else
                    r.was_hit = 1'b1;
                for (int i = 0; i < LINE_TOTAL; i++)
                    line_ag[i] = bump(line_ag[i]);
                reads = bump(reads);
                r.read_data = line_data[base+way][off];
            end
            CMD_WRITE:
            begin
                for (int w = 0; w < WAY_COUNT; w++)
                    if (line_vld[base+w] && line_tg[base+w] == tag)
                        line_data[base+w][off] = it.write_data;
                mem_shadow[it.address] = it.write_data;
            end
            CMD_FLUSH:
            begin
                for (int i = 0; i < MEM_BYTES; i++)
                    mem_shadow[i] = '0;
                for (int i = 0; i < LINE_TOTAL; i++)
                    line_vld[i] = 1'b0;
                misses = '0;
            end
            default:
            begin
            end
        endcase
        r.miss_total   = misses;
        r.access_total = reads;
        return r;
    endfunction

    // Watch both channels; results are checked before the new command is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_BYTES; i++)
                mem_shadow[i] = '0;
            for (int i = 0; i < LINE_TOTAL; i++)
            begin
                line_vld[i] = 1'b0;
                line_tg[i]  = '0;
                line_ag[i]  = '0;
                for (int j = 0; j < LINE_BYTES; j++)
                    line_data[i][j] = '0;
            end
            misses = '0;
            reads  = '0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t result with no pending command", $realtime);
                    err_count++;
                end
                else
                begin
                    out_item_t want;
                    want = expected_results.pop_front();
                    if (out_item.read_data !== want.read_data)
                        report_mismatch("read_data", out_item.read_data, want.read_data);
                    if (out_item.was_hit !== want.was_hit)
                        report_mismatch("was_hit", out_item.was_hit, want.was_hit);
                    if (out_item.miss_total !== want.miss_total)
                        report_mismatch("miss_total", out_item.miss_total, want.miss_total);
                    if (out_item.access_total !== want.access_total)
                        report_mismatch("access_total", out_item.access_total,
                                        want.access_total);
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(cache_result(in_item));
        end
        fail_count <= err_count + expected_results.size();
    end
endmodule

FILE: tb/tb_set_assoc_cache_fifo_wt.sv
// Top of the cache testbench: clock, reset, command stimulus and final verdict.
module tb_set_assoc_cache_fifo_wt;
    import sac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    int        fail_count;

    int send_idle_pct;
    int recv_idle_pct;
    int sent;
    int taken;
    int flushes_left;

    // Small pool of tags so that sets see both hits and evictions.
    logic [TAG_W-1:0] tag_pool [12];

    set_assoc_cache_fifo_wt u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    sac_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .fail_count (fail_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver side stalls at random.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Count taken results.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            taken++;

    // Sends one command transaction and waits until it is accepted.
    task automatic send_cmd(input cmd_t c, input logic [ADDR_W-1:0] a, input logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{command: c, address: a, write_data: d};
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    // Random command, mostly over the tag pool, some fully random.
    task automatic send_random();
        logic [ADDR_W-1:0] a;
        int                pick;
        cmd_t              c;
        pick = $urandom_range(999);
        if (pick < 600)
            c = CMD_READ;
        else if (pick < 960)
            c = CMD_WRITE;
        else if (pick < 997 || flushes_left == 0)
            c = CMD_NONE;
        else
        begin
            c = CMD_FLUSH;
            flushes_left--;
        end
        if ($urandom_range(99) < 80)
            a = {tag_pool[$urandom_range(11)], SET_W'($urandom_range(SET_COUNT-1)),
                 OFF_W'($urandom)};
        else
            a = ADDR_W'($urandom);
        send_cmd(c, a, 8'($urandom));
    endtask

    initial
    begin
        int total;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        send_idle_pct = 12;
        recv_idle_pct = 47;
        sent          = 0;
        flushes_left  = 3;
        for (int i = 0; i < 12; i++)
            tag_pool[i] = TAG_W'($urandom);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, hit after miss, write-through and eviction.
        send_cmd(CMD_READ, '0, 8'h00);
        send_cmd(CMD_READ, '0, 8'hff);
        send_cmd(CMD_WRITE, '1, 8'hff);
        send_cmd(CMD_READ, '1, 8'h00);
        send_cmd(CMD_WRITE, 16'h0005, 8'h5a);
        send_cmd(CMD_READ, 16'h0005, 8'h00);
        send_cmd(CMD_WRITE, 16'h0006, 8'h00);
        send_cmd(CMD_READ, 16'h0006, 8'h00);
        // Nine distinct tags in set zero force an eviction of the oldest way.
        for (int t = 1; t <= 9; t++)
            send_cmd(CMD_READ, {TAG_W'(t), SET_W'(0), OFF_W'(t)}, 8'h00);
        send_cmd(CMD_READ, 16'h0000, 8'h00);
        send_cmd(CMD_NONE, 16'h1234, 8'h77);
        send_cmd(CMD_FLUSH, '0, 8'h00);
        send_cmd(CMD_READ, '1, 8'h00);
        send_cmd(CMD_READ, '0, 8'h00);

        // Random part in three idling phases.
        total = 1880;
        for (int i = 0; i < total; i++)
        begin
            if (i == total / 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 12;
            end
            else if (i == 2 * total / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random();
        end
        in_valid <= 1'b0;

        while (taken < sent)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: filelist.f
src/sac_pkg.sv
src/sac_ram.sv
src/sac_dir.sv
src/set_assoc_cache_fifo_wt.sv
tb/sac_checker.sv
tb/tb_set_assoc_cache_fifo_wt.sv
